// ===== sv/mrrc_pkg.sv =====
// mrrc_pkg: shared constants for the modbus read response checker
// no dependencies; imported by mrrc_crc_step and modbus_read_response_checker
package mrrc_pkg;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam int POS_W = 5;

    localparam logic [1:0] REG_COUNT_RESET = 2'd2;

    localparam logic [POS_W-1:0] LEN_ONE_REG = 5'd5;
    localparam logic [POS_W-1:0] LEN_TWO_REG = 5'd7;

    localparam logic [POS_W-1:0] POS_FIRST_HI  = 5'd3;
    localparam logic [POS_W-1:0] POS_FIRST_LO  = 5'd4;
    localparam logic [POS_W-1:0] POS_SECOND_HI = 5'd5;
    localparam logic [POS_W-1:0] POS_SECOND_LO = 5'd6;
    localparam logic [POS_W-1:0] POS_LAST_OPEN = 5'd8;

endpackage

// ===== sv/mrrc_crc_step.sv =====
// mrrc_crc_step: one byte of crc-16/modbus, unrolled over the eight bits
// depends on mrrc_pkg for the polynomial
module mrrc_crc_step
    import mrrc_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        crc_out = c;
    end

endmodule

// ===== sv/modbus_read_response_checker.sv =====
// modbus_read_response_checker: top level of the modbus rtu read reply checker
// depends on mrrc_pkg and mrrc_crc_step
//
// usage:
//   input channel (in_valid/in_ready) carries one received byte per beat with
//   frame_start marking the first byte of a reply. output channel
//   (out_valid/out_ready) carries one verdict per completed frame: crc_ok,
//   first_value and second_value (zero when one register is configured).
//   cfg_we/cfg_wdata set the register count (1 or 2; 0 acts as 1, 3 as 2)
//   and may only be written while the block is idle.
// timing:
//   one byte per cycle sustained while in_ready is high. the crc and capture
//   update for a byte is done in the accepting cycle; the verdict for the crc
//   high byte is in the output register in the cycle after that byte's beat.
// reset:
//   waits for a frame start, register count 2, no result pending.
// stall:
//   in_ready drops only while a result is held and out_ready is low; the
//   held result stays unchanged until taken.
module modbus_read_response_checker
    import mrrc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        crc_ok,
    output logic [15:0] first_value,
    output logic [15:0] second_value
);

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    logic [1:0]       reg_count_reg;
    logic [15:0]      crc_reg, crc_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      first_reg, first_next;
    logic [15:0]      second_reg, second_next;
    logic [7:0]       crc_low_reg, crc_low_next;
    logic             finished_reg, finished_next;

    logic             out_valid_reg;
    logic             crc_ok_reg;
    logic [15:0]      first_value_reg;
    logic [15:0]      second_value_reg;

    logic [15:0]      cur_crc;
    logic [POS_W-1:0] cur_pos;
    logic [15:0]      cur_first;
    logic [15:0]      cur_second;
    logic [7:0]       cur_low;
    logic             cur_finished;
    logic [15:0]      crc_upd;
    logic             two_regs;
    logic [POS_W-1:0] len;
    logic             res_fire;
    logic             res_ok;
    logic             accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign two_regs = reg_count_reg[1];
    assign len      = two_regs ? LEN_TWO_REG : LEN_ONE_REG;

    // frame start clears state before the byte is handled
    assign cur_crc      = frame_start ? CRC_INIT : crc_reg;
    assign cur_pos      = frame_start ? '0 : pos_reg;
    assign cur_first    = frame_start ? 16'h0000 : first_reg;
    assign cur_second   = frame_start ? 16'h0000 : second_reg;
    assign cur_low      = frame_start ? 8'h00 : crc_low_reg;
    assign cur_finished = frame_start ? 1'b0 : finished_reg;

    mrrc_crc_step u_crc_step
    (
        .crc_in  (cur_crc),
        .data_in (rx_byte),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        crc_next      = cur_crc;
        pos_next      = cur_pos;
        first_next    = cur_first;
        second_next   = cur_second;
        crc_low_next  = cur_low;
        finished_next = cur_finished;
        res_fire      = 1'b0;
        res_ok        = (cur_low == cur_crc[7:0]) && (rx_byte == cur_crc[15:8]);
        if (!cur_finished)
        begin
            if (cur_pos >= POS_MAX || cur_pos > len + 5'd1)
            begin
                finished_next = 1'b1;
            end
            else if (cur_pos < len)
            begin
                crc_next = crc_upd;
                pos_next = cur_pos + 5'd1;
                case (cur_pos)
                    POS_FIRST_HI:  first_next[15:8]  = rx_byte;
                    POS_FIRST_LO:  first_next[7:0]   = rx_byte;
                    POS_SECOND_HI: second_next[15:8] = rx_byte;
                    POS_SECOND_LO: second_next[7:0]  = rx_byte;
                    default:       ;
                endcase
            end
            else if (cur_pos == len)
            begin
                crc_low_next = rx_byte;
                pos_next     = cur_pos + 5'd1;
            end
            else
            begin
                // crc high byte: verdict
                pos_next      = cur_pos + 5'd1;
                finished_next = 1'b1;
                res_fire      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_count_reg <= REG_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            reg_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= CRC_INIT;
            pos_reg      <= '0;
            first_reg    <= 16'h0000;
            second_reg   <= 16'h0000;
            crc_low_reg  <= 8'h00;
            finished_reg <= 1'b1;
        end
        else if (accept)
        begin
            crc_reg      <= crc_next;
            pos_reg      <= pos_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            crc_low_reg  <= crc_low_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= accept && res_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_fire)
        begin
            crc_ok_reg       <= res_ok;
            first_value_reg  <= cur_first;
            second_value_reg <= two_regs ? cur_second : 16'h0000;
        end
    end

    assign out_valid    = out_valid_reg;
    assign crc_ok       = crc_ok_reg;
    assign first_value  = first_value_reg;
    assign second_value = second_value_reg;

    // a new result only follows an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept))
        else $error("result without an accepted beat");

    // a verdict always closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> finished_reg)
        else $error("frame still open after verdict");

    // bytes outside a frame leave it closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !frame_start && finished_reg) |=> (finished_reg && $stable(pos_reg)))
        else $error("idle byte changed frame state");

    // an open frame never runs past the crc high byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !finished_reg |-> (pos_reg <= POS_LAST_OPEN))
        else $error("byte position out of range in open frame");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for modbus_read_response_checker, byte stream in, verdicts out
// holds a predicting scoreboard class and the drivers; depends on mrrc_pkg and the rtl top
module tb
    import mrrc_pkg::*;
();

    localparam int FRAME_BYTES_MAX = 16;
    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES = 105;
    localparam logic [7:0] READ_HOLDING = 8'h03;

    typedef struct packed {
        logic        crc_ok;
        logic [15:0] first_value;
        logic [15:0] second_value;
    } verdict_t;

    class reply_scoreboard;
        logic [1:0]  reg_count;
        logic [15:0] crc_acc;
        logic [4:0]  byte_pos;
        logic [15:0] cap_first;
        logic [15:0] cap_second;
        logic [7:0]  crc_low_rx;
        bit          waiting_start;
        verdict_t    verdict_q[$];
        int          errors;

        function new();
            reg_count = REG_COUNT_RESET;
            crc_acc = CRC_INIT;
            byte_pos = '0;
            cap_first = '0;
            cap_second = '0;
            crc_low_rx = '0;
            waiting_start = 1'b1;
            errors = 0;
        endfunction

        static function logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function int regs_used();
            if (reg_count == 2'd0)
                return 1;
            if (reg_count == 2'd3)
                return 2;
            return int'(reg_count);
        endfunction

        function void write_count(logic [1:0] v);
            reg_count = v;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function void note_byte(logic [7:0] b, logic s);
            int n;
            int len;
            int pos;
            verdict_t v;
            n = regs_used();
            len = 3 + 2 * n;
            if (s)
            begin
                crc_acc = CRC_INIT;
                byte_pos = '0;
                cap_first = '0;
                cap_second = '0;
                crc_low_rx = '0;
                waiting_start = 1'b0;
            end
            if (waiting_start)
                return;
            pos = int'(byte_pos);
            if (pos >= FRAME_BYTES_MAX || pos > len + 1)
            begin
                waiting_start = 1'b1;
                return;
            end
            if (pos < len)
            begin
                crc_acc = crc_update(crc_acc, b);
                case (pos)
                    3: cap_first[15:8] = b;
                    4: cap_first[7:0] = b;
                    5: cap_second[15:8] = b;
                    6: cap_second[7:0] = b;
                    default: ;
                endcase
                byte_pos = byte_pos + 5'd1;
                return;
            end
            if (pos == len)
            begin
                crc_low_rx = b;
                byte_pos = byte_pos + 5'd1;
                return;
            end
            byte_pos = byte_pos + 5'd1;
            waiting_start = 1'b1;
            v.crc_ok = (crc_low_rx == crc_acc[7:0]) && (b == crc_acc[15:8]);
            v.first_value = cap_first;
            v.second_value = (n == 2) ? cap_second : 16'h0000;
            verdict_q.push_back(v);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic ok, logic [15:0] f, logic [15:0] s);
            verdict_t want;
            if (verdict_q.size() == 0)
            begin
                report($sformatf("verdict with none expected: crc_ok=%0b first=%h second=%h",
                                 ok, f, s));
                return;
            end
            want = verdict_q.pop_front();
            if (ok !== want.crc_ok)
                report($sformatf("crc_ok got %0b want %0b", ok, want.crc_ok));
            if (f !== want.first_value)
                report($sformatf("first_value got %h want %h", f, want.first_value));
            if (s !== want.second_value)
                report($sformatf("second_value got %h want %h", s, want.second_value));
        endtask
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        frame_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        crc_ok;
    logic [15:0] first_value;
    logic [15:0] second_value;

    reply_scoreboard sb = new();
    bit          idle_off = 1'b0;
    logic [7:0]  reply_q[$];

    modbus_read_response_checker #(
        .MAX_FRAME_BYTES(FRAME_BYTES_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .frame_start(frame_start),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .crc_ok(crc_ok),
        .first_value(first_value),
        .second_value(second_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        if (idle_off || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // well-formed reply for n registers, crc appended low byte first
    function automatic void build_reply(logic [15:0] v1, logic [15:0] v2, int n);
        logic [15:0] crc;
        reply_q.delete();
        reply_q.push_back(8'($urandom));
        reply_q.push_back(READ_HOLDING);
        reply_q.push_back(8'(2 * n));
        reply_q.push_back(v1[15:8]);
        reply_q.push_back(v1[7:0]);
        if (n == 2)
        begin
            reply_q.push_back(v2[15:8]);
            reply_q.push_back(v2[7:0]);
        end
        crc = CRC_INIT;
        foreach (reply_q[i])
            crc = reply_scoreboard::crc_update(crc, reply_q[i]);
        reply_q.push_back(crc[7:0]);
        reply_q.push_back(crc[15:8]);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        frame_start <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b, s);
    endtask

    task automatic send_reply(input int upto);
        for (int i = 0; i < upto; i++)
            send_byte(reply_q[i], i == 0);
    endtask

    task automatic send_frame(output int sent);
        int n;
        int roll;
        int cut;
        int idx;
        int extra;
        roll = $urandom_range(0, 99);
        n = sb.regs_used();
        if (roll < 10)
            n = 3 - n;
        build_reply(pick_value(), pick_value(), n);
        cut = reply_q.size();
        if (roll >= 10 && roll < 25)
        begin
            idx = $urandom_range(0, reply_q.size() - 1);
            reply_q[idx] = reply_q[idx] ^ 8'($urandom_range(1, 255));
        end
        else if (roll >= 25 && roll < 35)
            cut = $urandom_range(1, reply_q.size() - 1);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        send_reply(cut);
        for (int i = 0; i < extra; i++)
            send_byte(8'($urandom), 1'b0);
        sent = cut + extra;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.write_count(v);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [1:0] count, input bit quiet);
        int sent;
        int sent_now;
        settle();
        write_count(count);
        idle_off = quiet;
        sent = 0;
        while (sent < PHASE_BYTES)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                sent++;
            end
            else
            begin
                send_frame(sent_now);
                sent += sent_now;
            end
        end
        // send the first bytes of a reply so the next count change can land mid-frame
        build_reply(pick_value(), pick_value(), sb.regs_used());
        send_reply($urandom_range(1, 8));
    endtask

    initial
    begin : receiver
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
            sb.check_result(crc_ok, first_value, second_value);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** modbus_read_response_checker: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset count of two: stray byte, restart mid-frame, extremes, bad crc high
        send_byte(8'hA5, 1'b0);
        send_byte(8'h11, 1'b1);
        send_byte(READ_HOLDING, 1'b0);
        build_reply(16'hFFFF, 16'h0000, sb.regs_used());
        send_reply(reply_q.size());
        build_reply(16'h0000, 16'hFFFF, sb.regs_used());
        reply_q[reply_q.size() - 1] = reply_q[reply_q.size() - 1] ^ 8'h80;
        send_reply(reply_q.size());

        run_phase(2'd1, 1'b0);
        run_phase(2'd3, 1'b1);
        run_phase(2'd0, 1'b0);
        run_phase(2'd2, 1'b0);
        run_phase(2'd1, 1'b1);
        run_phase(2'd3, 1'b0);

        settle();
        if (sb.errors == 0)
            $display("** modbus_read_response_checker: PASSED **");
        else
            $display("** modbus_read_response_checker: FAILED **");
        $finish;
    end
endmodule
